### hw/rtl/next_fit_handle_allocator_defines.svh
// Assertion macros for the next-fit handle allocator.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef NEXT_FIT_HANDLE_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_HANDLE_ALLOCATOR_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define NFHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define NFHA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/nfha_pkg.sv
// Package for the next-fit handle allocator: request and response beat types
// and the request, status and state codes. Depends on nothing.
`timescale 1ns / 1ps

package nfha_pkg;

	typedef enum logic [1:0] {
		REQ_ALLOC    = 2'd0,
		REQ_RELEASE  = 2'd1,
		REQ_IS_VALID = 2'd2,
		REQ_IS_ALLOC = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_FREE = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		req_code_t   req_type;
		logic [7:0]  handle;
		logic [15:0] requester_id;
	} req_t;

	typedef struct packed {
		logic [3:0] handle_out;
		status_t    status;
		logic       answer;
		logic [4:0] free_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

### hw/rtl/nfha_owner_mem.sv
// Owner id store of the handle allocator: one write port, one read port,
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module nfha_owner_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/nfha_slot_search.sv
// Rotated find-first-free over the slot assigned marks, starting at the
// search pointer and wrapping round. Depends on nothing.
`timescale 1ns / 1ps

module nfha_slot_search #(
	parameter int N  = 16,
	parameter int AW = 4
) (
	input  logic [N-1:0]  assigned,
	input  logic [AW-1:0] ptr,
	output logic          found,
	output logic [AW-1:0] slot
);

	logic [N-1:0] free_v;
	logic [N-1:0] above;
	logic [N-1:0] pick;
	logic [N-1:0] lowest;

	always_comb begin
		free_v = ~assigned;
		for (int i = 0; i < N; i++) begin
			above[i] = free_v[i] && ((AW+1)'(i) >= {1'b0, ptr});
		end
		// Free slots at or past the pointer win; otherwise wrap to the bottom.
		pick   = (|above) ? above : free_v;
		lowest = pick & (~pick + N'(1));
		slot   = '0;
		for (int i = 0; i < N; i++) begin
			if (lowest[i]) begin
				slot = slot | AW'(i);
			end
		end
		found = |free_v;
	end

endmodule

### hw/rtl/next_fit_handle_allocator.sv
// Next-fit handle allocator: top level. Uses nfha_pkg, nfha_owner_mem,
// nfha_slot_search and next_fit_handle_allocator_defines.svh.
// A request beat is accepted only in the idle state; the owner memory read at
// its handle is registered ahead of the execute step, which writes the response
// beat once the response register is free. A new request waits for that commit.
// Reset (arst_n low) frees every slot, zeroes the search pointer, sets the free
// count to NUM_HANDLES and clears check_owner; owner ids are not cleared.
`timescale 1ns / 1ps

module next_fit_handle_allocator #(
	parameter int NUM_HANDLES = 16,
	parameter int OWNER_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  nfha_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output nfha_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	import nfha_pkg::*;

	`include "next_fit_handle_allocator_defines.svh"

	localparam int IDX_W = $clog2(NUM_HANDLES);
	localparam int CNT_W = $clog2(NUM_HANDLES + 1);

	// Control state. The assigned marks live in flip-flops so that reset can
	// free every slot at once; owner ids live in the synchronous memory.
	state_t           state_q;
	logic [NUM_HANDLES-1:0] assigned_q;
	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] free_q;
	logic             check_owner_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// The request is captured at the accept edge, while the owner memory is
	// read at the requested handle in the same cycle.
	req_t             req_s1;
	logic             in_range_s1;
	logic [OWNER_BITS-1:0] who_s1;

	logic             accept;
	logic             commit;
	logic             in_range;
	logic [OWNER_BITS+15:0] who_ext;
	logic [IDX_W-1:0] idx_s1;
	logic [OWNER_BITS-1:0] owner_rd;
	logic             srch_found;
	logic [IDX_W-1:0] srch_slot;

	// Execute-step results.
	logic             set_en;
	logic             clr_en;
	logic [IDX_W-1:0] ptr_nxt;
	logic [CNT_W-1:0] free_nxt;
	logic [IDX_W-1:0] grant;
	status_t          stat;
	logic             ans;
	logic [IDX_W+3:0] grant_ext;
	logic [CNT_W+4:0] free_ext;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	// The response register is free when empty or when its beat leaves now.
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign cfg_ready = 1'b1;

	assign in_range = {1'b0, req.handle} < 9'(NUM_HANDLES);
	assign who_ext  = {{OWNER_BITS{1'b0}}, req.requester_id};
	assign idx_s1   = req_s1.handle[IDX_W-1:0];

	nfha_owner_mem #(
		.DEPTH (NUM_HANDLES),
		.WIDTH (OWNER_BITS),
		.AW    (IDX_W)
	) u_owner_mem (
		.clk   (clk),
		.we    (commit && set_en),
		.waddr (srch_slot),
		.wdata (who_s1),
		.re    (accept),
		.raddr (req.handle[IDX_W-1:0]),
		.rdata (owner_rd)
	);

	nfha_slot_search #(
		.N  (NUM_HANDLES),
		.AW (IDX_W)
	) u_slot_search (
		.assigned (assigned_q),
		.ptr      (ptr_q),
		.found    (srch_found),
		.slot     (srch_slot)
	);

	// Execute step: decide the response and the state update for one request.
	always_comb begin
		set_en   = 1'b0;
		clr_en   = 1'b0;
		ptr_nxt  = ptr_q;
		free_nxt = free_q;
		grant    = '0;
		stat     = STAT_OK;
		ans      = 1'b0;
		unique case (req_s1.req_type)
			REQ_ALLOC: begin
				if (srch_found) begin
					set_en   = 1'b1;
					grant    = srch_slot;
					free_nxt = free_q - CNT_W'(1);
					ptr_nxt  = (srch_slot == IDX_W'(NUM_HANDLES - 1)) ? '0
					           : srch_slot + IDX_W'(1);
				end else begin
					stat = STAT_NO_FREE;
				end
			end
			REQ_RELEASE: begin
				if (!in_range_s1) begin
					stat = STAT_RANGE;
				end else if (assigned_q[idx_s1]) begin
					clr_en   = 1'b1;
					free_nxt = free_q + CNT_W'(1);
				end
			end
			REQ_IS_VALID: begin
				if (in_range_s1) begin
					ans = assigned_q[idx_s1] && (!check_owner_q || owner_rd == who_s1);
				end
			end
			REQ_IS_ALLOC: begin
				if (!in_range_s1) begin
					stat = STAT_RANGE;
				end else begin
					ans = assigned_q[idx_s1];
				end
			end
			default: begin
				stat = STAT_OK;
			end
		endcase
		grant_ext = {4'b0, grant};
		free_ext  = {5'b0, free_nxt};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			in_range_s1 <= in_range;
			who_s1      <= who_ext[OWNER_BITS-1:0];
		end
		if (commit) begin
			rsp_q.handle_out <= grant_ext[3:0];
			rsp_q.status     <= stat;
			rsp_q.answer     <= ans;
			rsp_q.free_count <= free_ext[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			assigned_q    <= '0;
			ptr_q         <= '0;
			free_q        <= CNT_W'(NUM_HANDLES);
			check_owner_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				check_owner_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				ptr_q  <= ptr_nxt;
				free_q <= free_nxt;
				if (set_en) begin
					assigned_q[srch_slot] <= 1'b1;
				end
				if (clr_en) begin
					assigned_q[idx_s1] <= 1'b0;
				end
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The free count must always agree with the number of clear assigned marks.
	`NFHA_ASSERT(a_free_matches, free_q == CNT_W'(NUM_HANDLES - $countones(assigned_q)), "free count")
	// Only one request may be in flight: after an accept the input stalls.
	`NFHA_ASSERT(a_one_in_flight, accept |=> req_stall, "second request accepted in flight")
	// A new response beat appears only from the execute step.
	`NFHA_ASSERT(a_rsp_from_exec, $rose(rsp_valid_q) |-> $past(state_q == ST_EXEC), "stray beat")
	// A waiting response must not be overwritten by the next request.
	`NFHA_NEVER(a_no_overwrite, commit && rsp_valid_q && rsp_stall, "response overwritten")

endmodule
